FILE: rtl/core/pbb_pkg.sv
// Package for the path bounding box block: coordinate type, command codes,
// box and result structs, and the saturating add and box merge functions.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package pbb_pkg;

  // Coordinates are signed fixed point with 8 fraction bits; the block only
  // compares, adds and subtracts, so the binary point never shows in the logic.
  localparam int COORD_W    = 32;
  localparam int NUM_LANES  = 4;
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 4 * COORD_W;
  localparam int OUT_USER_W = 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Path command codes carried in the input tuser.
  typedef enum logic [2:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_CUBIC = 3'd2,
    CMD_QUAD  = 3'd3,
    CMD_ARC   = 3'd4,
    CMD_CLOSE = 3'd5,
    CMD_END   = 3'd6
  } cmd_t;

  // Extremes found so far: least and greatest x and y.
  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
  } box_t;

  // A box that leaves any other box unchanged when merged into it.
  localparam box_t BOX_NEUTRAL = '{lo_x: COORD_MAX, lo_y: COORD_MAX,
                                   hi_x: COORD_MIN, hi_y: COORD_MIN};

  // Per-transaction control that travels down the pipeline.
  typedef struct packed {
    logic is_end;
    logic seen;
  } item_ctrl_t;

  // What one lane is asked to fold: a plain point, or the pen widened by r.
  typedef struct packed {
    logic   use_pt;
    logic   widen;
    coord_t px;
    coord_t py;
    coord_t r;
  } lane_req_t;

  // One emitted box.
  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    coord_t             y;
    coord_t             x;
  } result_t;

  // a + b or a - b, clamped to the signed coordinate range.
  function automatic coord_t sat_add(coord_t a, coord_t b, logic sub);
    logic signed [COORD_W:0] s;
    coord_t                  res;
    if (sub) begin
      s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    end else begin
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    end
    if (s[COORD_W] != s[COORD_W-1]) begin
      res = s[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      res = s[COORD_W-1:0];
    end
    return res;
  endfunction

  // Union of two boxes: four independent signed compares.
  function automatic box_t box_merge(box_t a, box_t b);
    box_t m;
    m.lo_x = ($signed(b.lo_x) < $signed(a.lo_x)) ? b.lo_x : a.lo_x;
    m.lo_y = ($signed(b.lo_y) < $signed(a.lo_y)) ? b.lo_y : a.lo_y;
    m.hi_x = ($signed(b.hi_x) > $signed(a.hi_x)) ? b.hi_x : a.hi_x;
    m.hi_y = ($signed(b.hi_y) > $signed(a.hi_y)) ? b.hi_y : a.hi_y;
    return m;
  endfunction

endpackage

FILE: rtl/core/pbb_lane.sv
// One lane of the path bounding box: turns one point of a command into a
// registered candidate box. Depends on pbb_pkg.
`timescale 1ns / 1ps

module pbb_lane (
  input  logic              clk,
  input  logic              load,
  input  pbb_pkg::lane_req_t req,
  output pbb_pkg::box_t      cand
);
  import pbb_pkg::*;

  box_t cand_next;

  // An unused lane gives the neutral box; an arc lane widens the pen by r.
  always_comb begin
    if (!req.use_pt) begin
      cand_next = BOX_NEUTRAL;
    end else if (req.widen) begin
      cand_next.lo_x = sat_add(req.px, req.r, 1'b1);
      cand_next.lo_y = sat_add(req.py, req.r, 1'b1);
      cand_next.hi_x = sat_add(req.px, req.r, 1'b0);
      cand_next.hi_y = sat_add(req.py, req.r, 1'b0);
    end else begin
      cand_next.lo_x = req.px;
      cand_next.lo_y = req.py;
      cand_next.hi_x = req.px;
      cand_next.hi_y = req.py;
    end
  end

  // Candidate register, loaded whenever the first stage moves.
  always_ff @(posedge clk) begin
    if (load) begin
      cand <= cand_next;
    end
  end

endmodule

FILE: rtl/core/pbb_merge.sv
// Merging tree of the path bounding box: reduces the lane candidates of one
// transaction to a single box over two registered levels. Depends on pbb_pkg.
`timescale 1ns / 1ps

module pbb_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                a_valid,
  output logic                a_ready,
  input  pbb_pkg::box_t       lane_box [pbb_pkg::NUM_LANES],
  input  pbb_pkg::item_ctrl_t a_ctrl,
  output logic                c_valid,
  input  logic                c_ready,
  output pbb_pkg::box_t       c_box,
  output pbb_pkg::item_ctrl_t c_ctrl
);
  import pbb_pkg::*;

  logic       b_valid;
  box_t       b_box [2];
  item_ctrl_t b_ctrl;
  logic       en_b;
  logic       en_c;

  // A stage moves when it is empty or its contents move on.
  assign en_c    = !c_valid || c_ready;
  assign en_b    = !b_valid || en_c;
  assign a_ready = en_b;

  // Valid bits of the two merge levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
    end
  end

  // Pairwise merge of the lanes, then merge of the two pairs.
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_box[0] <= box_merge(lane_box[0], lane_box[1]);
      b_box[1] <= box_merge(lane_box[2], lane_box[3]);
      b_ctrl   <= a_ctrl;
    end
    if (en_c) begin
      c_box  <= box_merge(b_box[0], b_box[1]);
      c_ctrl <= b_ctrl;
    end
  end

endmodule

FILE: rtl/core/pbb_fold.sv
// Running box of the path bounding box: folds each transaction's box into the
// path extremes and emits the result register on an end command. Depends on pbb_pkg.
`timescale 1ns / 1ps

module pbb_fold (
  input  logic                clk,
  input  logic                rst,
  input  logic                c_valid,
  output logic                c_ready,
  input  pbb_pkg::box_t       c_box,
  input  pbb_pkg::item_ctrl_t c_ctrl,
  output logic                out_valid,
  input  logic                out_ready,
  output pbb_pkg::result_t    result
);
  import pbb_pkg::*;

  box_t run_box;
  logic run_seen;
  logic fire;

  // Only an end waits for the result register; all else folds at once.
  assign c_ready = !c_ctrl.is_end || !out_valid || out_ready;
  assign fire    = c_valid && c_ready;

  // Running extremes and the output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_box   <= BOX_NEUTRAL;
      run_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire && c_ctrl.is_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (c_ctrl.is_end) begin
          run_box   <= BOX_NEUTRAL;
          run_seen  <= 1'b0;
        end else begin
          run_box  <= box_merge(run_box, c_box);
          run_seen <= run_seen || c_ctrl.seen;
        end
      end
    end
  end

  // Result register; an empty path reports zeros and the empty flag.
  always_ff @(posedge clk) begin
    if (fire && c_ctrl.is_end) begin
      if (run_seen) begin
        result.x     <= run_box.lo_x;
        result.y     <= run_box.lo_y;
        result.w     <= run_box.hi_x - run_box.lo_x;
        result.h     <= run_box.hi_y - run_box.lo_y;
        result.empty <= 1'b0;
      end else begin
        result.x     <= '0;
        result.y     <= '0;
        result.w     <= '0;
        result.h     <= '0;
        result.empty <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/path_bounding_box_top.sv
// Top level of the path bounding box: input decode, pen tracking, four
// point lanes, the merge tree and the running fold. Depends on pbb_pkg,
// pbb_lane, pbb_merge and pbb_fold.
`timescale 1ns / 1ps

// The block takes one path command per clock and keeps the axis-aligned box of
// every control point and end point; an arc adds its two points and the pen
// widened by the radius. An end command's box passes the pair and final merge
// registers into the result register, and the path is cleared. The pipeline has
// four register levels: lane candidates, pair merge, final merge, and the
// running fold with its result register. Input stalls only when a result waits
// to be taken, a second end has reached the final merge register, and the lane
// and pair merge registers behind it both hold transactions. The pen is updated
// at acceptance, so each command sees the pen left by the one before it.
module path_bounding_box_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pt_a_x, pt_a_y, pt_b_x, pt_b_y, pt_c_x, pt_c_y
  input  logic [pbb_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  logic [pbb_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // box_x, box_y, box_w, box_h
  output logic [pbb_pkg::OUT_DATA_W-1:0]   m_tdata,
  // box_empty
  output logic [pbb_pkg::OUT_USER_W-1:0]   m_tuser
);
  import pbb_pkg::*;

  cmd_t       cmd;
  coord_t     pt_a_x, pt_a_y, pt_b_x, pt_b_y, pt_c_x, pt_c_y;
  coord_t     pen_x, pen_y, start_x, start_y;
  logic       in_fire;
  logic       a_valid;
  logic       a_ready;
  item_ctrl_t a_ctrl;
  item_ctrl_t ctrl_next;
  lane_req_t  lane_req [NUM_LANES];
  box_t       lane_box [NUM_LANES];
  logic       c_valid;
  logic       c_ready;
  box_t       c_box;
  item_ctrl_t c_ctrl;
  result_t    result;

  // Unpack the input transaction.
  assign cmd    = cmd_t'(s_tuser);
  assign pt_a_x = s_tdata[0*COORD_W +: COORD_W];
  assign pt_a_y = s_tdata[1*COORD_W +: COORD_W];
  assign pt_b_x = s_tdata[2*COORD_W +: COORD_W];
  assign pt_b_y = s_tdata[3*COORD_W +: COORD_W];
  assign pt_c_x = s_tdata[4*COORD_W +: COORD_W];
  assign pt_c_y = s_tdata[5*COORD_W +: COORD_W];

  assign s_tready = !a_valid || a_ready;
  assign in_fire  = s_tvalid && s_tready;

  // Lane requests: three plain points and the widened pen of an arc.
  always_comb begin
    lane_req[0] = '{use_pt: cmd inside {CMD_MOVE, CMD_LINE, CMD_CUBIC, CMD_QUAD, CMD_ARC},
                    widen: 1'b0, px: pt_a_x, py: pt_a_y, r: '0};
    lane_req[1] = '{use_pt: cmd inside {CMD_CUBIC, CMD_QUAD, CMD_ARC},
                    widen: 1'b0, px: pt_b_x, py: pt_b_y, r: '0};
    lane_req[2] = '{use_pt: cmd == CMD_CUBIC,
                    widen: 1'b0, px: pt_c_x, py: pt_c_y, r: '0};
    lane_req[3] = '{use_pt: cmd == CMD_ARC,
                    widen: 1'b1, px: pen_x, py: pen_y, r: pt_c_x};
    ctrl_next.is_end = (cmd == CMD_END);
    ctrl_next.seen   = lane_req[0].use_pt;
  end

  // Point lanes.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    pbb_lane u_lane (
      .clk  (clk),
      .load (s_tready),
      .req  (lane_req[i]),
      .cand (lane_box[i])
    );
  end

  // First stage valid bit and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      a_ctrl <= ctrl_next;
    end
  end

  // Pen and subpath start follow every accepted command.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= '0;
      pen_y   <= '0;
      start_x <= '0;
      start_y <= '0;
    end else if (in_fire) begin
      case (cmd)
        CMD_MOVE: begin
          pen_x   <= pt_a_x;
          pen_y   <= pt_a_y;
          start_x <= pt_a_x;
          start_y <= pt_a_y;
        end
        CMD_LINE: begin
          pen_x <= pt_a_x;
          pen_y <= pt_a_y;
        end
        CMD_CUBIC: begin
          pen_x <= pt_c_x;
          pen_y <= pt_c_y;
        end
        CMD_QUAD, CMD_ARC: begin
          pen_x <= pt_b_x;
          pen_y <= pt_b_y;
        end
        CMD_CLOSE: begin
          pen_x <= start_x;
          pen_y <= start_y;
        end
        CMD_END: begin
          pen_x   <= '0;
          pen_y   <= '0;
          start_x <= '0;
          start_y <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Merge tree over the lanes.
  pbb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .a_valid  (a_valid),
    .a_ready  (a_ready),
    .lane_box (lane_box),
    .a_ctrl   (a_ctrl),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_box    (c_box),
    .c_ctrl   (c_ctrl)
  );

  // Running box and result register.
  pbb_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .c_valid   (c_valid),
    .c_ready   (c_ready),
    .c_box     (c_box),
    .c_ctrl    (c_ctrl),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // Pack the output transaction.
  assign m_tdata = {result.h, result.w, result.y, result.x};
  assign m_tuser = result.empty;

endmodule

FILE: rtl/core/pbb_checker.sv
// Port-level checks for the path bounding box, bound to the top level.
// Depends on pbb_pkg and path_bounding_box_top.
`timescale 1ns / 1ps

module pbb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [pbb_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [pbb_pkg::IN_USER_W-1:0]  s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pbb_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [pbb_pkg::OUT_USER_W-1:0] m_tuser
);
  import pbb_pkg::*;

  // A result that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  // An empty path reports an all-zero box.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("empty box with nonzero fields");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // With the output side always ready the block never stalls its input.
  a_no_stall: assert property (@(posedge clk)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

endmodule

bind path_bounding_box_top pbb_checker u_pbb_checker (.*);
